// ===== design/gtp_pkg.sv =====
// Package for the Goertzel tone power block.
// Field widths, fixed-point constants and the serial multiplier status type.
// No dependencies.
package gtp_pkg;

  localparam int SampleW = 16;
  localparam int CoefFrac = 14;
  localparam int PowerW = 32;
  localparam int McandW = 18;
  localparam int ProdW = 32;
  localparam int MplierW = 16;
  localparam int CntW = $clog2(MplierW);

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ===== design/goertzel_tone_power.sv =====
// Goertzel tone power detector, top level: sequencer, delay registers, output register.
// One serial multiplier (gtp_mult) serves the recurrence and the power terms.
// A new sample is taken only in the idle state, after the bit-serial multiply for the previous one has finished.
// A sample marked last runs six multiplies before its result is loaded and out_tvalid rises.
// A pending result waits in the output register while the next transaction is taken.
// Reset (rst_n low, synchronous) clears the delays, the coefficient and all control state.
module goertzel_tone_power #(
  parameter int INPUT_SHIFT = 2,
  parameter int POWER_SHIFT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,     // coefficient
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // sample
  input  logic        in_tlast,      // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata      // power
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StWait  = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  localparam logic [2:0] StepRecX  = 3'd0;
  localparam logic [2:0] StepRec0  = 3'd1;
  localparam logic [2:0] StepCoef  = 3'd2;
  localparam logic [2:0] StepCross = 3'd3;
  localparam logic [2:0] StepSq1   = 3'd4;
  localparam logic [2:0] StepSq2   = 3'd5;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        last_r, last_nxt;
  logic signed [gtp_pkg::SampleW-1:0] coef_r;
  logic signed [gtp_pkg::SampleW-1:0] d1_r, d1_nxt;
  logic signed [gtp_pkg::SampleW-1:0] d2_r, d2_nxt;
  logic signed [gtp_pkg::SampleW-1:0] x_r, x_nxt;
  logic signed [gtp_pkg::McandW-1:0]  t_r, t_nxt;
  logic [gtp_pkg::PowerW-1:0]         pw_r, pw_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [gtp_pkg::PowerW-1:0]         out_data_r, out_data_nxt;

  logic                               mul_start;
  logic signed [gtp_pkg::McandW-1:0]  mul_mcand;
  logic signed [gtp_pkg::MplierW-1:0] mul_mplier;
  gtp_pkg::mul_stat_t                 mul_stat;
  logic [gtp_pkg::ProdW-1:0]          mul_prod;
  logic [gtp_pkg::SampleW-1:0]        rec_next;

  gtp_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  assign in_tready  = (state_r == StIdle);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rec_next = x_r + mul_prod[gtp_pkg::CoefFrac +: gtp_pkg::SampleW] - d2_r;

  always_comb begin
    case (step_r)
      StepCross: begin
        mul_mcand  = t_r;
        mul_mplier = d2_r;
      end
      StepSq1: begin
        mul_mcand  = gtp_pkg::McandW'(d1_r);
        mul_mplier = d1_r;
      end
      StepSq2: begin
        mul_mcand  = gtp_pkg::McandW'(d2_r);
        mul_mplier = d2_r;
      end
      default: begin
        mul_mcand  = gtp_pkg::McandW'(d1_r);
        mul_mplier = coef_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    last_nxt      = last_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    x_nxt         = x_r;
    t_nxt         = t_r;
    pw_nxt        = pw_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      StIdle: begin
        if (in_tvalid) begin
          x_nxt     = $signed(in_tdata) >>> INPUT_SHIFT;
          last_nxt  = in_tlast;
          step_nxt  = StepRecX;
          state_nxt = StIssue;
        end
      end
      StIssue: begin
        mul_start = 1'b1;
        state_nxt = StWait;
      end
      StWait: begin
        if (mul_stat.done) begin
          state_nxt = StIssue;
          case (step_r)
            StepRecX: begin
              d2_nxt = d1_r;
              d1_nxt = rec_next;
              x_nxt  = '0;
              if (last_r) begin
                step_nxt = StepRec0;
              end else begin
                state_nxt = StIdle;
              end
            end
            StepRec0: begin
              d2_nxt   = d1_r;
              d1_nxt   = rec_next;
              step_nxt = StepCoef;
            end
            StepCoef: begin
              t_nxt    = mul_prod[gtp_pkg::CoefFrac +: gtp_pkg::McandW];
              step_nxt = StepCross;
            end
            StepCross: begin
              pw_nxt   = ~mul_prod + 1'b1;
              step_nxt = StepSq1;
            end
            StepSq1: begin
              pw_nxt   = pw_r + mul_prod;
              step_nxt = StepSq2;
            end
            default: begin
              pw_nxt    = pw_r + mul_prod;
              state_nxt = StOut;
            end
          endcase
        end
      end
      default: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pw_r << POWER_SHIFT;
          d1_nxt        = '0;
          d2_nxt        = '0;
          step_nxt      = StepRecX;
          state_nxt     = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      step_r      <= StepRecX;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      coef_r      <= '0;
      d1_r        <= '0;
      d2_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      d1_r        <= d1_nxt;
      d2_r        <= d2_nxt;
      if (cfg_we) begin
        coef_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    t_r        <= t_nxt;
    pw_r       <= pw_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== design/gtp_mult.sv =====
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Product is reduced modulo 2^32. Depends on gtp_pkg.
module gtp_mult (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [gtp_pkg::McandW-1:0]  mcand,
  input  logic signed [gtp_pkg::MplierW-1:0] mplier,
  output gtp_pkg::mul_stat_t                  stat,
  output logic [gtp_pkg::ProdW-1:0]          product
);

  logic [gtp_pkg::ProdW-1:0]   acc_r, acc_nxt;
  logic [gtp_pkg::ProdW-1:0]   mc_r, mc_nxt;
  logic [gtp_pkg::MplierW-1:0] mq_r, mq_nxt;
  logic [gtp_pkg::CntW-1:0]    cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [gtp_pkg::ProdW-1:0]   addend;

  localparam logic [gtp_pkg::CntW-1:0] LastBit = gtp_pkg::CntW'(gtp_pkg::MplierW - 1);

  always_comb begin
    if (!mq_r[0]) begin
      addend = '0;
    end else if (cnt_r == LastBit) begin
      addend = ~mc_r + 1'b1;
    end else begin
      addend = mc_r;
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mq_nxt   = mq_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      mc_nxt   = gtp_pkg::ProdW'(mcand);
      mq_nxt   = mplier;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + addend;
      mc_nxt  = {mc_r[gtp_pkg::ProdW-2:0], 1'b0};
      mq_nxt  = {1'b0, mq_r[gtp_pkg::MplierW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LastBit) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mq_r  <= mq_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule
